// ===== rtl/wildcard_byte_pattern_scan_assert.svh =====
// Assertion macros for the wildcard byte pattern scan.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WBPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scan.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int MAX_PATTERN       = 16;
  localparam int LEN_BITS          = 5;
  localparam int PAT_IDX_BITS      = 4;
  localparam int OFFSET_OUT_BITS   = 32;
  localparam int CFG_INDEX_BITS    = 8;
  localparam int CFG_DATA_BITS     = 64;
  localparam int DEF_PATTERN_BYTES = 16;
  localparam int DEF_OFFSET_BITS   = 32;

  typedef logic [7:0] byte_t;
  typedef logic [MAX_PATTERN-1:0][7:0] pattern_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PATTERN_LOW  = 8'd0,
    CFG_PATTERN_HIGH = 8'd1,
    CFG_WILDCARD     = 8'd2,
    CFG_LENGTH       = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic                       found;
    logic [OFFSET_OUT_BITS-1:0] match_offset;
  } result_t;

endpackage

// ===== rtl/wbps_if.sv =====
// Handshake interfaces for the byte input, result output and register write channels.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

interface wbps_in_if;
  logic                valid;
  logic                ready;
  wbps_pkg::byte_t     data_byte;
  logic                last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   found;
  logic [wbps_pkg::OFFSET_OUT_BITS-1:0]   match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

interface wbps_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [wbps_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [wbps_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/wbps_cell.sv =====
// One window cell: holds a single stream byte, passes it on to the next cell and
// compares the byte entering it against its pattern position. Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wbps_pkg::cell_ctrl_t               ctrl_i,
  input  wbps_pkg::byte_t                    byte_i,
  input  wbps_pkg::pattern_t                 pattern_i,
  input  logic [wbps_pkg::MAX_PATTERN-1:0]   wildcard_i,
  input  logic [wbps_pkg::LEN_BITS-1:0]      length_i,
  output wbps_pkg::byte_t                    byte_o,
  output logic                               hit_o
);
  import wbps_pkg::*;

  localparam logic [LEN_BITS-1:0] CELL_POS = LEN_BITS'(CELL_INDEX);

  byte_t                   byte_q, byte_d;
  logic                    active;
  logic [LEN_BITS-1:0]     pat_pos;
  logic [PAT_IDX_BITS-1:0] pat_idx;

  // Cell k sees window entry k, which meets pattern byte length-1-k.
  always_comb begin
    active  = CELL_POS < length_i;
    pat_pos = length_i - LEN_BITS'(1) - CELL_POS;
    pat_idx = pat_pos[PAT_IDX_BITS-1:0];
    hit_o   = !active || wildcard_i[pat_idx] || (pattern_i[pat_idx] == byte_i);
  end

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.clear ? '0 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== rtl/wildcard_byte_pattern_scan.sv =====
// Top level of the wildcard byte pattern scan: register file, row of window cells,
// region counter and a two-entry result buffer. Depends on wbps_pkg, wbps_if and wbps_cell.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_scan_assert.svh"

// Scans a byte stream for the first place in each region where a pattern of up to
// PATTERN_BYTES bytes matches, each pattern byte optionally a wildcard. One byte is
// taken per clock cycle while input ready is high: the incoming byte and the bytes held in
// the row of cells are compared with the pattern combinationally, and the result is
// registered into a two-entry output buffer and presented once earlier results are
// delivered. Input ready drops only while two results wait undelivered.
// A region gives exactly one result: found with the start offset on the byte that
// completes the first match, or not found on its last byte. The pattern, the wildcard
// mask and the pattern length are written through the register channel, which is
// always ready; write them between regions while no result is outstanding.
module wildcard_byte_pattern_scan #(
  parameter int PATTERN_BYTES = wbps_pkg::DEF_PATTERN_BYTES,
  parameter int OFFSET_BITS   = wbps_pkg::DEF_OFFSET_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wbps_cfg_if.sink    cfg_i,
  wbps_in_if.sink     in_i,
  wbps_out_if.source  out_o
);
  import wbps_pkg::*;

  localparam logic [LEN_BITS-1:0]    LEN_MAX   = LEN_BITS'(PATTERN_BYTES);
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  // Register file
  logic [CFG_DATA_BITS-1:0] pat_lo_q, pat_hi_q;
  logic [MAX_PATTERN-1:0]   wild_q;
  logic [LEN_BITS-1:0]      len_q;
  pattern_t                 pattern;
  logic [LEN_BITS-1:0]      len_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      wild_q   <= '0;
      len_q    <= LEN_BITS'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_PATTERN_LOW:  pat_lo_q <= cfg_i.data;
        CFG_PATTERN_HIGH: pat_hi_q <= cfg_i.data;
        CFG_WILDCARD:     wild_q   <= cfg_i.data[MAX_PATTERN-1:0];
        CFG_LENGTH:       len_q    <= cfg_i.data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign pattern = {pat_hi_q, pat_lo_q};

  always_comb begin
    len_eff = len_q;
    if (len_q == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (len_q > LEN_MAX) begin
      len_eff = LEN_MAX;
    end
  end

  // Input handshake and cell row
  logic                     in_acc;
  cell_ctrl_t               cell_ctrl;
  byte_t                    cell_in  [PATTERN_BYTES];
  byte_t                    cell_out [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] cell_hit;

  logic [1:0] cnt_q, cnt_d;

  assign in_i.ready      = (cnt_q != 2'd2);
  assign in_acc          = in_i.valid && in_i.ready;
  assign cell_ctrl.shift = in_acc;
  assign cell_ctrl.clear = in_i.last_byte;

  for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = in_i.data_byte;
    end else begin : g_body
      assign cell_in[k] = cell_out[k-1];
    end

    wbps_cell #(
      .CELL_INDEX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .byte_i     (cell_in[k]),
      .pattern_i  (pattern),
      .wildcard_i (wild_q),
      .length_i   (len_eff),
      .byte_o     (cell_out[k]),
      .hit_o      (cell_hit[k])
    );
  end

  // Region counter and match decision
  logic [OFFSET_BITS-1:0]     seen_q, seen_d, seen_inc, off_full;
  logic                       reported_q, reported_d;
  logic                       counted, match, push;
  logic [OFFSET_OUT_BITS-1:0] off_out;
  result_t                    push_res;

  assign counted  = (seen_q != COUNT_MAX);
  assign seen_inc = seen_q + OFFSET_BITS'(1);
  assign off_full = seen_inc - {{(OFFSET_BITS-LEN_BITS){1'b0}}, len_eff};

  if (OFFSET_BITS >= OFFSET_OUT_BITS) begin : g_off_trunc
    assign off_out = off_full[OFFSET_OUT_BITS-1:0];
  end else begin : g_off_ext
    assign off_out = {{(OFFSET_OUT_BITS-OFFSET_BITS){1'b0}}, off_full};
  end

  always_comb begin
    match = !reported_q && counted && (&cell_hit)
            && (seen_inc >= {{(OFFSET_BITS-LEN_BITS){1'b0}}, len_eff});
    push  = in_acc && (match || (in_i.last_byte && !reported_q));
    push_res.found        = match;
    push_res.match_offset = match ? off_out : '0;

    seen_d     = seen_q;
    reported_d = reported_q;
    if (in_acc) begin
      if (in_i.last_byte) begin
        seen_d     = '0;
        reported_d = 1'b0;
      end else begin
        seen_d     = counted ? seen_inc : seen_q;
        reported_d = reported_q || match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

  // Two-entry result buffer
  result_t res_q [2];
  logic    wr_ptr_q, rd_ptr_q;
  logic    pop;

  assign pop                = out_o.valid && out_o.ready;
  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.found        = res_q[rd_ptr_q].found;
  assign out_o.match_offset = res_q[rd_ptr_q].match_offset;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q[wr_ptr_q] <= push_res;
    end
  end

  `WBPS_ASSERT_IMP(a_buf_bound, 1'b1, cnt_q <= 2'd2, "result buffer overfilled")
  `WBPS_ASSERT_IMP(a_notfound_zero, out_o.valid && !out_o.found, out_o.match_offset == '0, "not-found result carries an offset")
  `WBPS_ASSERT_NEXT(a_region_clear, in_acc && in_i.last_byte, seen_q == '0 && !reported_q, "region state not cleared after last byte")
  `WBPS_ASSERT_IMP(a_one_per_region, in_acc && reported_q, !push, "second result in one region")
  `WBPS_ASSERT_IMP(a_sat_no_match, in_acc && !counted, !match, "match reported past counter saturation")
  `WBPS_ASSERT_NEXT(a_push_shows, push, out_o.valid, "pushed result not presented")

endmodule

// ===== dv/wildcard_byte_pattern_scan_test.sv =====
// Self-checking bench for the wildcard byte pattern scan: drives regions of bytes,
// predicts one found or not-found result per region and checks them in order.
// Depends on wbps_pkg, the wbps handshake interfaces and the wildcard_byte_pattern_scan top.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_test;
  import wbps_pkg::*;

  localparam int PHASE_ITEMS   = 175;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int QUIET_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 20;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 8'd200;

  typedef struct packed {
    byte_t data;
    logic  last;
  } scan_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wbps_cfg_if cfg_if ();
  wbps_in_if  in_if ();
  wbps_out_if out_if ();

  wildcard_byte_pattern_scan dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Register copies and region state of the scanner
  logic [CFG_DATA_BITS-1:0]   pattern_low  = '0;
  logic [CFG_DATA_BITS-1:0]   pattern_high = '0;
  logic [MAX_PATTERN-1:0]     wildcard_bits = '0;
  logic [LEN_BITS-1:0]        length_field = LEN_BITS'(1);
  byte_t                      window_bytes [MAX_PATTERN];
  logic [DEF_OFFSET_BITS-1:0] region_count = '0;
  bit                         region_matched = 1'b0;

  scan_item_t byte_feed [$];
  result_t    results_due [$];
  byte_t      region_bytes [$];

  int feed_idle_pct   = 0;
  int drain_stall_pct = 0;
  int bytes_fed       = 0;
  int bytes_taken     = 0;
  int regions_closed  = 0;
  int hits_checked    = 0;
  int misses_checked  = 0;
  int mismatches      = 0;
  int quiet_cycles    = 0;

  function automatic int effective_length();
    if (length_field == 0) return 1;
    if (length_field > MAX_PATTERN) return MAX_PATTERN;
    return int'(length_field);
  endfunction

  function automatic byte_t pattern_byte_at(int pos);
    logic [2*CFG_DATA_BITS-1:0] both;
    both = {pattern_high, pattern_low};
    return both[8*pos +: 8];
  endfunction

  // Advance the window by one byte and queue the result it causes, if any
  task automatic scan_byte(input byte_t data, input logic last);
    int      len;
    bit      counted;
    bit      hit;
    result_t verdict;
    len     = effective_length();
    counted = (region_count != '1);
    for (int i = MAX_PATTERN - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
    window_bytes[0] = data;
    if (counted) region_count++;
    if (!region_matched && counted && region_count >= len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        if (!wildcard_bits[i] && pattern_byte_at(i) != window_bytes[len-1-i]) hit = 1'b0;
      end
      if (hit) begin
        region_matched       = 1'b1;
        verdict.found        = 1'b1;
        verdict.match_offset = region_count - len;
        results_due.push_back(verdict);
      end
    end
    if (last) begin
      if (!region_matched) begin
        verdict = '0;
        results_due.push_back(verdict);
      end
      foreach (window_bytes[i]) window_bytes[i] = '0;
      region_count   = '0;
      region_matched = 1'b0;
      regions_closed++;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_PATTERN_LOW:  pattern_low   = value;
      CFG_PATTERN_HIGH: pattern_high  = value;
      CFG_WILDCARD:     wildcard_bits = value[MAX_PATTERN-1:0];
      CFG_LENGTH:       length_field  = value[LEN_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic feed_region();
    scan_item_t item;
    foreach (region_bytes[k]) begin
      item.data = region_bytes[k];
      item.last = (k == region_bytes.size() - 1);
      byte_feed.push_back(item);
      bytes_fed++;
    end
  endtask

  // Random bytes with pattern bytes mixed in, then up to two planted copies, some broken
  task automatic build_region();
    int len;
    int n;
    int pos;
    len = effective_length();
    region_bytes.delete();
    case ($urandom_range(9))
      0:       n = $urandom_range(len, 1);
      1:       n = $urandom_range(300, 64);
      default: n = $urandom_range(len + 24, len);
    endcase
    for (int k = 0; k < n; k++)
      region_bytes.push_back($urandom_range(1) ? byte_t'($urandom())
                                               : pattern_byte_at($urandom_range(len - 1)));
    for (int c = 0; c < 2; c++) begin
      if (n < len || $urandom_range(3) == 0) break;
      pos = $urandom_range(n - len);
      for (int i = 0; i < len; i++)
        if (!wildcard_bits[i]) region_bytes[pos+i] = pattern_byte_at(i);
      if ($urandom_range(4) == 0)
        region_bytes[pos + $urandom_range(len - 1)] ^= byte_t'(1 << $urandom_range(7));
    end
  endtask

  // Hold until every byte is taken and every result is in, then let the pipeline empty
  task automatic await_drain();
    do @(posedge clk_i);
    while (bytes_taken != bytes_fed || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_DATA_BITS-1:0] low, input logic [CFG_DATA_BITS-1:0] high,
                           input logic [CFG_DATA_BITS-1:0] mask, input logic [CFG_DATA_BITS-1:0] len,
                           input int feed_idle, input int drain_stall, input bit pause_midway);
    int target;
    bit paused;
    write_register(CFG_PATTERN_LOW, low);
    write_register(CFG_PATTERN_HIGH, high);
    write_register(CFG_WILDCARD, mask);
    write_register(CFG_LENGTH, len);
    write_register(CFG_UNMAPPED, {$urandom(), $urandom()});
    feed_idle_pct   = feed_idle;
    drain_stall_pct = drain_stall;
    target = bytes_fed + PHASE_ITEMS;
    paused = 1'b0;
    while (bytes_fed < target) begin
      build_region();
      feed_region();
      if (pause_midway && !paused && bytes_fed >= target - PHASE_ITEMS / 2) begin
        await_drain();
        paused = 1'b1;
      end
    end
    await_drain();
  endtask

  always @(posedge clk_i) begin : byte_driver
    scan_item_t item;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        scan_byte(in_if.data_byte, in_if.last_byte);
        bytes_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_feed.size() != 0 && $urandom_range(99) >= feed_idle_pct) begin
          item = byte_feed.pop_front();
          in_if.valid     <= 1'b1;
          in_if.data_byte <= item.data;
          in_if.last_byte <= item.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with none outstanding", out_if.match_offset, '0);
        end else begin
          want = results_due.pop_front();
          if (out_if.found !== want.found)
            report_mismatch("found flag", out_if.found, want.found);
          if (out_if.match_offset !== want.match_offset)
            report_mismatch("match offset", out_if.match_offset, want.match_offset);
          if (want.found) hits_checked++;
          else misses_checked++;
        end
      end
      out_if.ready <= ($urandom_range(99) >= drain_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (window_bytes[i]) window_bytes[i] = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset pattern: a single zero byte
    region_bytes = '{8'h00};
    feed_region();
    region_bytes = '{8'h37, 8'h00};
    feed_region();
    await_drain();

    // FF, wildcard, 00, A5
    write_register(CFG_PATTERN_LOW, 64'hC3C3_C3C3_A500_5AFF);
    write_register(CFG_WILDCARD, 64'h0000_0000_0000_0002);
    write_register(CFG_LENGTH, 64'd4);
    region_bytes = '{8'h00, 8'hFF, 8'h12, 8'h00, 8'hA5, 8'h77};
    feed_region();
    region_bytes = '{8'hFF, 8'h5A, 8'h00};
    feed_region();
    region_bytes = '{8'hFF, 8'h34, 8'h00, 8'hA5};
    feed_region();
    region_bytes = '{8'hFF};
    feed_region();
    region_bytes = '{8'h01, 8'hFF, 8'hFF, 8'h00, 8'hA5, 8'hFF, 8'hEE, 8'h00, 8'hA5};
    feed_region();
    await_drain();

    run_phase({$urandom(), $urandom()}, {$urandom(), $urandom()}, 64'd0, 64'd16, 0, 0, 1'b0);
    run_phase({$urandom(), $urandom()}, {$urandom(), $urandom()}, 64'd0, 64'd1, 75, 0, 1'b0);
    // zero length behaves as one
    run_phase({$urandom(), $urandom()}, {$urandom(), $urandom()}, {$urandom(), $urandom()},
              64'd0, 0, 75, 1'b0);
    // 31 clamps to the full width, everything wildcard
    run_phase({$urandom(), $urandom()}, {$urandom(), $urandom()}, '1, '1, 11, 11, 1'b0);
    run_phase('1, '1, {$urandom(), $urandom()},
              {32'($urandom()), 27'($urandom()), 5'($urandom_range(15, 2))}, 0, 0, 1'b1);
    run_phase('0, '0, '0, 64'd17, 75, 0, 1'b0);
    run_phase({$urandom(), $urandom()}, {$urandom(), $urandom()}, 64'(16'($urandom())),
              64'($urandom_range(16, 1)), 0, 75, 1'b0);
    run_phase({$urandom(), $urandom()}, {$urandom(), $urandom()}, {$urandom(), $urandom()},
              64'($urandom_range(16, 1)), 11, 11, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Scanned %0d bytes in %0d regions under 10 register settings", bytes_taken,
             regions_closed);
    $display("Checked %0d found and %0d not-found results, %0d mismatches", hits_checked,
             misses_checked, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wbps_pkg.sv
rtl/wbps_if.sv
rtl/wbps_cell.sv
rtl/wildcard_byte_pattern_scan.sv
dv/wildcard_byte_pattern_scan_test.sv
